// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is held
`define MVDA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// clocked assertion that also holds during reset
`define MVDA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

// ----- rtl/mvda_pkg.sv -----
// shared types and constants of the muon veto dead-time accumulator
// no dependencies
`default_nettype none

package mvda_pkg;

  // number of antineutrino detectors tracked
  localparam int NUM_ADS = 4;
  // detectors shown on the result item
  localparam int ADS_OUT = 4;
  // highest AD id plus one that the detector code can name
  localparam int AD_ID_LIMIT = (NUM_ADS < 4) ? NUM_ADS : 4;

  localparam int DET_W      = 3;
  localparam int STRENGTH_W = 20;
  localparam int TIME_W     = 48;
  localparam int ACC_W      = 64;
  localparam int PRE_W      = 24;
  localparam int CUT_W      = 20;
  localparam int POST_W     = 30;
  localparam int END_W      = TIME_W + 1;
  localparam int DELTA_W    = TIME_W + 2;
  localparam int ADD_W      = POST_W + 1;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 30;

  localparam logic [CFG_IDX_W-1:0] CFG_PRE_VETO    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_CUT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_POST   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AD_CUT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_AD_POST     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOWER_CUT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SHOWER_POST = 3'd6;

  // detector codes of the water pool
  localparam logic [DET_W-1:0] DET_INNER_POOL = 3'd4;
  localparam logic [DET_W-1:0] DET_OUTER_POOL = 3'd5;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_POOL   = 2'd1,
    KIND_AD     = 2'd2,
    KIND_SHOWER = 2'd3
  } kind_e;

  typedef struct packed {
    logic [PRE_W-1:0]  pre_veto;
    logic [CUT_W-1:0]  pool_cut;
    logic [POST_W-1:0] pool_post;
    logic [CUT_W-1:0]  ad_cut;
    logic [POST_W-1:0] ad_post;
    logic [CUT_W-1:0]  shower_cut;
    logic [POST_W-1:0] shower_post;
  } cfg_t;

  // per-detector update request from the classing stage
  typedef struct packed {
    logic              charge;
    kind_e             kind;
    logic [TIME_W-1:0] event_time;
  } lane_upd_t;

endpackage

`default_nettype wire

// ----- rtl/mvda_stream_if.sv -----
// valid/ready channels for muon items and result items
// depends on mvda_pkg
`default_nettype none

interface mvda_in_if import mvda_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [DET_W-1:0]      detector_id;
  logic [STRENGTH_W-1:0] strength;
  logic [TIME_W-1:0]     event_time_ns;

  modport source (output valid, detector_id, strength, event_time_ns, input ready);
  modport sink   (input valid, detector_id, strength, event_time_ns, output ready);
endinterface

interface mvda_out_if import mvda_pkg::*; ();
  logic             valid;
  logic             ready;
  kind_e            muon_kind;
  logic [ACC_W-1:0] dead_ad1_ns;
  logic [ACC_W-1:0] dead_ad2_ns;
  logic [ACC_W-1:0] dead_ad3_ns;
  logic [ACC_W-1:0] dead_ad4_ns;

  modport source (output valid, muon_kind, dead_ad1_ns, dead_ad2_ns, dead_ad3_ns,
                  dead_ad4_ns, input ready);
  modport sink   (input valid, muon_kind, dead_ad1_ns, dead_ad2_ns, dead_ad3_ns,
                  dead_ad4_ns, output ready);
endinterface

`default_nettype wire

// ----- rtl/mvda_cfg_regs.sv -----
// configuration register file: cuts and veto lengths
// depends on mvda_pkg
`default_nettype none

module mvda_cfg_regs import mvda_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                       cfg_o
);

  cfg_t cfg_q;

  // register writes, unknown indexes dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pre_veto    <= PRE_W'(2000);
      cfg_q.pool_cut    <= CUT_W'(12);
      cfg_q.pool_post   <= POST_W'(600000);
      cfg_q.ad_cut      <= CUT_W'(3000);
      cfg_q.ad_post     <= POST_W'(1400000);
      cfg_q.shower_cut  <= CUT_W'(300000);
      cfg_q.shower_post <= POST_W'(400000000);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PRE_VETO:    cfg_q.pre_veto    <= cfg_data_i[PRE_W-1:0];
        CFG_POOL_CUT:    cfg_q.pool_cut    <= cfg_data_i[CUT_W-1:0];
        CFG_POOL_POST:   cfg_q.pool_post   <= cfg_data_i[POST_W-1:0];
        CFG_AD_CUT:      cfg_q.ad_cut      <= cfg_data_i[CUT_W-1:0];
        CFG_AD_POST:     cfg_q.ad_post     <= cfg_data_i[POST_W-1:0];
        CFG_SHOWER_CUT:  cfg_q.shower_cut  <= cfg_data_i[CUT_W-1:0];
        CFG_SHOWER_POST: cfg_q.shower_post <= cfg_data_i[POST_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ----- rtl/mvda_lane.sv -----
// one detector lane: last AD and shower times, veto end, dead-time accumulator
// depends on mvda_pkg
`default_nettype none

module mvda_lane import mvda_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  cfg_t                   cfg_i,
  input  lane_upd_t              upd_i,
  input  wire logic [TIME_W-1:0] last_pool_i,
  output logic [ACC_W-1:0]       acc_o
);

  logic [TIME_W-1:0] last_ad_q, last_shower_q;
  logic [ACC_W-1:0]  acc_q, acc_d;

  logic [END_W-1:0]         pool_end, ad_end, shower_end, veto_end;
  logic [POST_W-1:0]        post;
  logic signed [DELTA_W-1:0] delta, pre_ext, post_ext, delta_post;
  logic [ADD_W-1:0]         add;

  // end of the running veto window
  always_comb begin
    pool_end   = {1'b0, last_pool_i}   + END_W'(cfg_i.pool_post);
    ad_end     = {1'b0, last_ad_q}     + END_W'(cfg_i.ad_post);
    shower_end = {1'b0, last_shower_q} + END_W'(cfg_i.shower_post);
    veto_end   = (pool_end > ad_end) ? pool_end : ad_end;
    if (shower_end > veto_end) veto_end = shower_end;
  end

  // post-veto of the current class
  always_comb begin
    unique case (upd_i.kind)
      KIND_POOL:   post = cfg_i.pool_post;
      KIND_SHOWER: post = cfg_i.shower_post;
      KIND_AD:     post = cfg_i.ad_post;
      default:     post = cfg_i.ad_post;
    endcase
  end

  // new dead time not covered by the running window
  always_comb begin
    delta      = $signed({2'b00, upd_i.event_time}) - $signed({1'b0, veto_end});
    pre_ext    = $signed(DELTA_W'(cfg_i.pre_veto));
    post_ext   = $signed(DELTA_W'(post));
    delta_post = delta + post_ext;
    priority if (delta >= pre_ext) begin
      add = ADD_W'(cfg_i.pre_veto) + ADD_W'(post);
    end else if (delta >= -post_ext) begin
      add = delta_post[ADD_W-1:0];
    end else begin
      add = '0;
    end
    acc_d = acc_q + ACC_W'(add);
  end

  // lane state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_ad_q     <= '0;
      last_shower_q <= '0;
      acc_q         <= '0;
    end else if (upd_i.charge) begin
      acc_q <= acc_d;
      if (upd_i.kind == KIND_AD)     last_ad_q     <= upd_i.event_time;
      if (upd_i.kind == KIND_SHOWER) last_shower_q <= upd_i.event_time;
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

// ----- rtl/muon_veto_deadtime_accumulator.sv -----
// Muon veto dead-time accumulator, top level.
// Path: input register, then lane/result registers; classing, veto end, delta
// and accumulate for every AD lane sit between them. Throughput: one item per
// cycle while the result channel is not stalled.
// Reset: clears all last-time registers and accumulators, loads default cuts
// and veto lengths; no clearing pass, ready right after reset.
`default_nettype none

module muon_veto_deadtime_accumulator import mvda_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  mvda_in_if.sink                    in_i,
  mvda_out_if.source                 out_o
);

  cfg_t cfg;

  mvda_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // input register
  logic                  in_valid_q;
  logic [DET_W-1:0]      det_q;
  logic [STRENGTH_W-1:0] strength_q;
  logic [TIME_W-1:0]     time_q;
  logic                  out_valid_q;
  kind_e                 kind_q;
  logic                  fire;

  assign fire       = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      det_q      <= in_i.detector_id;
      strength_q <= in_i.strength;
      time_q     <= in_i.event_time_ns;
    end
  end

  // muon classing
  logic  is_pool_det, is_ad_det;
  kind_e kind;

  always_comb begin
    is_pool_det = (det_q == DET_INNER_POOL) || (det_q == DET_OUTER_POOL);
    is_ad_det   = det_q < DET_W'(AD_ID_LIMIT);
    priority if (is_pool_det && strength_q > cfg.pool_cut) begin
      kind = KIND_POOL;
    end else if (is_ad_det && strength_q > cfg.shower_cut) begin
      kind = KIND_SHOWER;
    end else if (is_ad_det && strength_q > cfg.ad_cut) begin
      kind = KIND_AD;
    end else begin
      kind = KIND_NONE;
    end
  end

  // shared pool time
  logic [TIME_W-1:0] last_pool_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_pool_q <= '0;
    end else if (fire && kind == KIND_POOL) begin
      last_pool_q <= time_q;
    end
  end

  // detector lanes
  lane_upd_t        upd [NUM_ADS];
  logic [ACC_W-1:0] acc [NUM_ADS];

  for (genvar i = 0; i < NUM_ADS; i++) begin : g_lane
    always_comb begin
      upd[i].kind       = kind;
      upd[i].event_time = time_q;
      upd[i].charge     = fire && ((kind == KIND_POOL) ||
                          ((kind == KIND_AD || kind == KIND_SHOWER) &&
                           det_q == DET_W'(i)));
    end

    mvda_lane u_lane (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cfg_i       (cfg),
      .upd_i       (upd[i]),
      .last_pool_i (last_pool_q),
      .acc_o       (acc[i])
    );
  end

  // result register; accumulators change only when the next result loads
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      kind_q      <= KIND_NONE;
    end else if (fire) begin
      out_valid_q <= 1'b1;
      kind_q      <= kind;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  logic [ACC_W-1:0] dead_out [ADS_OUT];

  for (genvar i = 0; i < ADS_OUT; i++) begin : g_out
    if (i < NUM_ADS) begin : g_used
      assign dead_out[i] = acc[i];
    end else begin : g_unused
      assign dead_out[i] = '0;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.muon_kind   = kind_q;
  assign out_o.dead_ad1_ns = dead_out[0];
  assign out_o.dead_ad2_ns = dead_out[1];
  assign out_o.dead_ad3_ns = dead_out[2];
  assign out_o.dead_ad4_ns = dead_out[3];

endmodule

`default_nettype wire

// ----- rtl/mvda_checker.sv -----
// port-level checks of the dead-time accumulator result channel, with its bind
// depends on mvda_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module mvda_checker import mvda_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input kind_e                 out_kind,
  input wire logic [ACC_W-1:0] dead1,
  input wire logic [ACC_W-1:0] dead2,
  input wire logic [ACC_W-1:0] dead3,
  input wire logic [ACC_W-1:0] dead4
);

  // accumulators of the last delivered result item
  logic [ACC_W-1:0] prev1_q, prev2_q, prev3_q, prev4_q;
  logic [ADS_OUT-1:0] chg;
  logic [ADS_OUT*ACC_W-1:0] dead_all;
  logic stall, ignored_item, ad_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev1_q <= '0;
      prev2_q <= '0;
      prev3_q <= '0;
      prev4_q <= '0;
    end else if (out_valid && out_ready) begin
      prev1_q <= dead1;
      prev2_q <= dead2;
      prev3_q <= dead3;
      prev4_q <= dead4;
    end
  end

  assign chg = {dead4 != prev4_q, dead3 != prev3_q, dead2 != prev2_q, dead1 != prev1_q};

  // offered result item seen by the checks
  assign dead_all     = {dead4, dead3, dead2, dead1};
  assign stall        = out_valid && !out_ready;
  assign ignored_item = out_valid && (out_kind == KIND_NONE);
  assign ad_item      = out_valid && ((out_kind == KIND_AD) || (out_kind == KIND_SHOWER));

  `MVDA_ASSERT_RST(a_no_result_in_reset, !rst_ni |-> !out_valid, "result offered in reset")
  `MVDA_ASSERT(a_result_held, stall |=> out_valid, "result item dropped")
  `MVDA_ASSERT(a_result_stable, stall |=> $stable({out_kind, dead_all}), "stalled result changed")
  `MVDA_ASSERT(a_ignored_no_charge, ignored_item |-> chg == '0, "ignored muon changed dead time")
  `MVDA_ASSERT(a_single_ad_charge, ad_item |-> $countones(chg) <= 1, "AD muon charged several ADs")

endmodule

bind muon_veto_deadtime_accumulator mvda_checker u_mvda_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_kind  (out_o.muon_kind),
  .dead1     (out_o.dead_ad1_ns),
  .dead2     (out_o.dead_ad2_ns),
  .dead3     (out_o.dead_ad3_ns),
  .dead4     (out_o.dead_ad4_ns)
);

`default_nettype wire
